>>> rtl/lrbc_pkg.sv
// Shared types, codes and reset values for the link retry backoff controller.
`timescale 1ns / 1ps

package lrbc_pkg;

    localparam int unsigned NUM_EVENTS  = 6;
    localparam int unsigned EVT_IDX_W   = $clog2(NUM_EVENTS);
    localparam int unsigned EVT_CNT_W   = $clog2(NUM_EVENTS + 1);
    localparam int unsigned CFG_INDEX_W = 4;
    localparam int unsigned CFG_DATA_W  = 32;
    localparam int unsigned TIME_W      = 32;
    localparam int unsigned DELAY_W     = 16;
    localparam int unsigned SHIFT_W     = 5;

    localparam logic [TIME_W-1:0]  ATTEMPT_TIMEOUT_RST = 32'd15000;
    localparam logic [DELAY_W-1:0] FIRST_DELAY_RST     = 16'd1000;
    localparam logic [TIME_W-1:0]  MAX_DELAY_RST       = 32'd60000;
    localparam logic [SHIFT_W-1:0] MAX_SHIFT_RST       = 5'd6;

    typedef enum logic [1:0] {
        REQ_TICK    = 2'd0,
        REQ_INIT    = 2'd1,
        REQ_RESTART = 2'd2
    } req_t;

    typedef enum logic [1:0] {
        STAT_CONNECTED = 2'd0,
        STAT_FAILED    = 2'd1,
        STAT_NO_SSID   = 2'd2,
        STAT_OTHER     = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        LK_DISABLED     = 2'd0,
        LK_CONNECTING   = 2'd1,
        LK_CONNECTED    = 2'd2,
        LK_DISCONNECTED = 2'd3
    } link_t;

    typedef enum logic [1:0] {
        ACT_NOTICE = 2'd0,
        ACT_CANCEL = 2'd1,
        ACT_BEGIN  = 2'd2,
        ACT_DONE   = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        CAUSE_NONE       = 3'd0,
        CAUSE_TIMEOUT    = 3'd1,
        CAUSE_FAILED     = 3'd2,
        CAUSE_LINK_LOST  = 3'd3,
        CAUSE_REJECTED   = 3'd4,
        CAUSE_NO_PROFILE = 3'd5
    } cause_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_ATTEMPT_TIMEOUT = 4'd0,
        CFG_FIRST_DELAY     = 4'd1,
        CFG_MAX_DELAY       = 4'd2,
        CFG_MAX_SHIFT       = 4'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [TIME_W-1:0]  attempt_timeout_ms;
        logic [DELAY_W-1:0] first_retry_delay_ms;
        logic [TIME_W-1:0]  max_retry_delay_ms;
        logic [SHIFT_W-1:0] max_retry_shift;
    } cfg_t;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [TIME_W-1:0] now_ms;
        status_t           radio_status;
        logic              any_network_configured;
        logic              active_profile_present;
        logic              begin_rejected;
    } item_t;

    typedef struct packed {
        link_t              link;
        logic               in_flight;
        logic [SHIFT_W-1:0] backoff_shift;
        logic [TIME_W-1:0]  attempt_start_ms;
        logic [TIME_W-1:0]  retry_at_ms;
        logic               initialized;
    } state_t;

    typedef struct packed {
        action_t           action;
        link_t             link;
        cause_t            cause;
        logic [TIME_W-1:0] deadline;
    } evt_t;

    typedef evt_t [NUM_EVENTS-1:0] evt_arr_t;

endpackage

>>> rtl/lrbc_step.sv
// Single-pass evaluation of one request: next state and the list of result events.
`timescale 1ns / 1ps

module lrbc_step (
    input  lrbc_pkg::cfg_t                      cfg,
    input  lrbc_pkg::state_t                    st,
    input  lrbc_pkg::item_t                     item,
    output lrbc_pkg::state_t                    st_next,
    output lrbc_pkg::evt_arr_t                  evts,
    output logic [lrbc_pkg::EVT_CNT_W-1:0]      evt_count
);
    import lrbc_pkg::*;

    localparam int unsigned SHIFTED_W = DELAY_W + (1 << SHIFT_W) - 1;

    typedef struct packed {
        logic [SHIFT_W-1:0] shift;
        logic [TIME_W-1:0]  delay;
    } plan_t;

    // Append one event while room is left.
    function automatic void push(inout evt_arr_t ev, inout logic [EVT_CNT_W-1:0] cnt,
                                 input action_t a, input link_t l, input cause_t c,
                                 input logic [TIME_W-1:0] dl);
        if (cnt < EVT_CNT_W'(NUM_EVENTS))
        begin
            ev[cnt[EVT_IDX_W-1:0]] = '{action: a, link: l, cause: c, deadline: dl};
            cnt = cnt + EVT_CNT_W'(1);
        end
    endfunction

    // Move the link and post a notice, only on a real change.
    function automatic void change(inout link_t ls, inout evt_arr_t ev,
                                   inout logic [EVT_CNT_W-1:0] cnt, input link_t nxt,
                                   input cause_t c, input logic [TIME_W-1:0] dl);
        if (nxt != ls)
        begin
            ls = nxt;
            push(ev, cnt, ACT_NOTICE, ls, c, dl);
        end
    endfunction

    // Shifted delay capped at the maximum, and the advanced shift.
    function automatic plan_t plan(input logic [SHIFT_W-1:0] sh, input cfg_t c);
        logic [SHIFTED_W-1:0] shifted;
        plan_t                p;
        shifted = {{(SHIFTED_W-DELAY_W){1'b0}}, c.first_retry_delay_ms} << sh;
        if (shifted > {{(SHIFTED_W-TIME_W){1'b0}}, c.max_retry_delay_ms})
            p.delay = c.max_retry_delay_ms;
        else
            p.delay = shifted[TIME_W-1:0];
        p.shift = (sh < c.max_retry_shift) ? sh + SHIFT_W'(1) : sh;
        return p;
    endfunction

    link_t                  ls;
    logic                   inf;
    logic [SHIFT_W-1:0]     sh;
    logic [TIME_W-1:0]      ast;
    logic [TIME_W-1:0]      rt;
    logic                   ini;
    evt_arr_t               ev;
    logic [EVT_CNT_W-1:0]   cnt;
    logic                   start_attempt;
    logic                   due;
    logic                   failed;
    logic                   expired;
    logic [TIME_W-1:0]      elapsed;
    logic [TIME_W-1:0]      since_retry;
    plan_t                  pl_fail;
    plan_t                  pl_rej;

    always_comb
    begin
        ls            = st.link;
        inf           = st.in_flight;
        sh            = st.backoff_shift;
        ast           = st.attempt_start_ms;
        rt            = st.retry_at_ms;
        ini           = st.initialized;
        ev            = '0;
        cnt           = '0;
        start_attempt = 1'b0;
        pl_fail       = '0;
        pl_rej        = '0;

        elapsed     = item.now_ms - st.attempt_start_ms;
        since_retry = item.now_ms - st.retry_at_ms;
        expired     = elapsed >= cfg.attempt_timeout_ms;
        failed      = (item.radio_status == STAT_FAILED) || (item.radio_status == STAT_NO_SSID);
        due         = ~since_retry[TIME_W-1];

        unique case (item.req_type)
            REQ_INIT:
            begin
                ini = 1'b1;
                if (!item.any_network_configured)
                    ls = LK_DISABLED;
                else
                    start_attempt = 1'b1;
            end
            REQ_TICK:
            begin
                if (ls != LK_DISABLED)
                begin
                    if (item.radio_status == STAT_CONNECTED)
                    begin
                        if (ls != LK_CONNECTED)
                        begin
                            inf = 1'b0;
                            sh  = '0;
                            change(ls, ev, cnt, LK_CONNECTED, CAUSE_NONE, rt);
                        end
                    end
                    else
                    begin
                        if (inf)
                        begin
                            if (failed || expired)
                            begin
                                inf = 1'b0;
                                if (!failed)
                                begin
                                    push(ev, cnt, ACT_CANCEL, ls, CAUSE_TIMEOUT, rt);
                                    change(ls, ev, cnt, LK_DISCONNECTED, CAUSE_TIMEOUT, rt);
                                end
                                else
                                begin
                                    change(ls, ev, cnt, LK_DISCONNECTED, CAUSE_FAILED, rt);
                                end
                                pl_fail = plan(sh, cfg);
                                sh      = pl_fail.shift;
                                rt      = item.now_ms + pl_fail.delay;
                                // now - (now + d) is non-negative only for d of zero or above 2^31
                                due     = (pl_fail.delay == '0) ||
                                          (pl_fail.delay[TIME_W-1] &&
                                           (pl_fail.delay[TIME_W-2:0] != '0));
                            end
                        end
                        else if (ls == LK_CONNECTED)
                        begin
                            change(ls, ev, cnt, LK_DISCONNECTED, CAUSE_LINK_LOST, rt);
                            pl_fail = plan(sh, cfg);
                            sh      = pl_fail.shift;
                            rt      = item.now_ms + pl_fail.delay;
                            due     = (pl_fail.delay == '0) ||
                                      (pl_fail.delay[TIME_W-1] &&
                                       (pl_fail.delay[TIME_W-2:0] != '0));
                        end
                        if (!inf && (ls != LK_CONNECTED) && due)
                            start_attempt = 1'b1;
                    end
                end
            end
            REQ_RESTART:
            begin
                if (ini && item.any_network_configured)
                begin
                    push(ev, cnt, ACT_CANCEL, ls, CAUSE_NONE, rt);
                    inf           = 1'b0;
                    sh            = '0;
                    start_attempt = 1'b1;
                end
            end
            default: ;
        endcase

        if (start_attempt)
        begin
            if (!item.active_profile_present)
            begin
                change(ls, ev, cnt, LK_DISABLED, CAUSE_NO_PROFILE, rt);
            end
            else
            begin
                ast = item.now_ms;
                inf = 1'b1;
                change(ls, ev, cnt, LK_CONNECTING, CAUSE_NONE, rt);
                push(ev, cnt, ACT_BEGIN, ls, CAUSE_NONE, rt);
                if (item.begin_rejected)
                begin
                    inf = 1'b0;
                    change(ls, ev, cnt, LK_DISCONNECTED, CAUSE_REJECTED, rt);
                    pl_rej = plan(sh, cfg);
                    sh     = pl_rej.shift;
                    rt     = item.now_ms + pl_rej.delay;
                end
            end
        end

        push(ev, cnt, ACT_DONE, ls, CAUSE_NONE, rt);

        st_next.link             = ls;
        st_next.in_flight        = inf;
        st_next.backoff_shift    = sh;
        st_next.attempt_start_ms = ast;
        st_next.retry_at_ms      = rt;
        st_next.initialized      = ini;
        evts                     = ev;
        evt_count                = cnt;
    end

endmodule

>>> rtl/link_retry_backoff_controller.sv
// Top level of the link retry backoff controller: input register, step logic, result drain.
`timescale 1ns / 1ps

// Link retry controller with capped exponential backoff. Each request transfer
// (tick, init or restart) is held in an input register, then evaluated combinationally
// against the link state and the configuration; the evaluation writes between one
// and six result items into a result buffer and updates the state at the same edge.
// The buffer drains one result per cycle on the output channel while out_ready is
// high, the last one of a request being the done item (last high). A request
// therefore places one to six results on the output; the result buffer, which is
// refilled in the cycle its final item transfers, sets the sustained rate. The
// first result of a request appears once it has passed the input register and
// been loaded into the result buffer. The input register takes the next request
// while the buffer still drains, so both sides can stall freely. Configuration
// writes are always ready and take effect at once; write them only while no
// request is pending. Retries are scheduled at first_retry_delay_ms << backoff_shift,
// capped at max_retry_delay_ms, and the deadline test is a wrap-safe signed
// difference on now_ms.
module link_retry_backoff_controller (
    input  logic                                clk,
    input  logic                                rst_n,
    // request channel
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [1:0]                          req_type,
    input  logic [lrbc_pkg::TIME_W-1:0]         now_ms,
    input  logic [1:0]                          radio_status,
    input  logic                                any_network_configured,
    input  logic                                active_profile_present,
    input  logic                                begin_rejected,
    // result channel
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [1:0]                          action,
    output logic [1:0]                          link,
    output logic [2:0]                          cause,
    output logic [lrbc_pkg::TIME_W-1:0]         retry_deadline_ms,
    output logic                                last,
    // configuration write channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [lrbc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [lrbc_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import lrbc_pkg::*;

    // configuration
    cfg_t                   cfg_reg;

    // request held for evaluation
    logic                   in_valid_reg;
    item_t                  item_reg;
    logic                   in_xfer;

    // controller state
    state_t                 state_reg;
    state_t                 state_next;

    // result buffer
    evt_arr_t               ev_reg;
    evt_arr_t               ev_next;
    logic [EVT_CNT_W-1:0]   cnt_reg;
    logic [EVT_CNT_W-1:0]   cnt_next;
    logic [EVT_CNT_W-1:0]   cnt_eval;
    logic [EVT_IDX_W-1:0]   idx_reg;
    logic [EVT_IDX_W-1:0]   idx_next;
    evt_t                   cur_evt;
    logic                   buf_valid;
    logic                   buf_last;
    logic                   out_xfer;
    logic                   load;

    // Configuration port: always ready, unknown indexes are dropped.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.attempt_timeout_ms   <= ATTEMPT_TIMEOUT_RST;
            cfg_reg.first_retry_delay_ms <= FIRST_DELAY_RST;
            cfg_reg.max_retry_delay_ms   <= MAX_DELAY_RST;
            cfg_reg.max_retry_shift      <= MAX_SHIFT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_ATTEMPT_TIMEOUT: cfg_reg.attempt_timeout_ms   <= cfg_data[TIME_W-1:0];
                CFG_FIRST_DELAY:     cfg_reg.first_retry_delay_ms <= cfg_data[DELAY_W-1:0];
                CFG_MAX_DELAY:       cfg_reg.max_retry_delay_ms   <= cfg_data[TIME_W-1:0];
                CFG_MAX_SHIFT:       cfg_reg.max_retry_shift      <= cfg_data[SHIFT_W-1:0];
                default: ;
            endcase
        end
    end

    // Result buffer status: the current entry, and whether it closes the request.
    assign buf_valid = (cnt_reg != '0);
    assign cur_evt   = ev_reg[idx_reg];
    assign buf_last  = (EVT_CNT_W'(idx_reg) == (cnt_reg - EVT_CNT_W'(1)));
    assign out_xfer  = buf_valid && out_ready;

    // Evaluate the held request once the buffer is empty or empties this cycle.
    assign load     = in_valid_reg && (!buf_valid || (out_xfer && buf_last));
    assign in_ready = !in_valid_reg || load;
    assign in_xfer  = in_valid && in_ready;

    lrbc_step u_step (
        .cfg       (cfg_reg),
        .st        (state_reg),
        .item      (item_reg),
        .st_next   (state_next),
        .evts      (ev_next),
        .evt_count (cnt_eval)
    );

    // Drain pointer: restart on load, advance on each transfer, drop after the last.
    always_comb
    begin
        cnt_next = cnt_reg;
        idx_next = idx_reg;
        if (load)
        begin
            cnt_next = cnt_eval;
            idx_next = '0;
        end
        else if (out_xfer)
        begin
            if (buf_last)
            begin
                cnt_next = '0;
                idx_next = '0;
            end
            else
            begin
                idx_next = idx_reg + EVT_IDX_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            cnt_reg      <= '0;
            idx_reg      <= '0;
            state_reg    <= '{link: LK_DISABLED, in_flight: 1'b0, backoff_shift: '0,
                              attempt_start_ms: '0, retry_at_ms: '0, initialized: 1'b0};
        end
        else
        begin
            if (in_xfer)
                in_valid_reg <= 1'b1;
            else if (load)
                in_valid_reg <= 1'b0;
            cnt_reg <= cnt_next;
            idx_reg <= idx_next;
            if (load)
                state_reg <= state_next;
        end
    end

    // Payload registers: hold until a new transfer or a new evaluation.
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            item_reg.req_type               <= req_type;
            item_reg.now_ms                 <= now_ms;
            item_reg.radio_status           <= status_t'(radio_status);
            item_reg.any_network_configured <= any_network_configured;
            item_reg.active_profile_present <= active_profile_present;
            item_reg.begin_rejected         <= begin_rejected;
        end
        if (load)
            ev_reg <= ev_next;
    end

    // Result port.
    assign out_valid         = buf_valid;
    assign action            = cur_evt.action;
    assign link              = cur_evt.link;
    assign cause             = cur_evt.cause;
    assign retry_deadline_ms = cur_evt.deadline;
    assign last              = buf_last;

endmodule

>>> rtl/lrbc_checker.sv
// Port-level checks for the link retry backoff controller, bound to the top level.
`timescale 1ns / 1ps

module lrbc_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic                                in_ready,
    input  logic [1:0]                          req_type,
    input  logic [lrbc_pkg::TIME_W-1:0]         now_ms,
    input  logic [1:0]                          radio_status,
    input  logic                                any_network_configured,
    input  logic                                active_profile_present,
    input  logic                                begin_rejected,
    input  logic                                out_valid,
    input  logic                                out_ready,
    input  logic [1:0]                          action,
    input  logic [1:0]                          link,
    input  logic [2:0]                          cause,
    input  logic [lrbc_pkg::TIME_W-1:0]         retry_deadline_ms,
    input  logic                                last,
    input  logic                                cfg_valid,
    input  logic                                cfg_ready,
    input  logic [lrbc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [lrbc_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import lrbc_pkg::*;

    // A stalled result holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(action) && $stable(link) &&
                                    $stable(cause) && $stable(retry_deadline_ms) &&
                                    $stable(last))
        else $error("result changed while stalled");

    // Every request closes with exactly its done item.
    a_last_is_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (last == (action == ACT_DONE)))
        else $error("last flag and done action disagree");

    // Done carries no cause.
    a_done_no_cause: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last |-> cause == CAUSE_NONE)
        else $error("done item with a cause");

    // A begin is always issued from the connecting state.
    a_begin_connecting: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && action == ACT_BEGIN |-> link == LK_CONNECTING && cause == CAUSE_NONE)
        else $error("begin issued outside connecting");

endmodule

bind link_retry_backoff_controller lrbc_checker u_lrbc_checker (.*);
